// ===== rtl/ptmx_pkg.sv =====
// Shared types and constants for the persistent trie max-xor block.
// No dependencies; used by persistent_trie_max_xor and the testbench.
`timescale 1ns / 1ps

package ptmx_pkg;

    localparam int COUNT_BITS = 11;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_QUERY  = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_POOL_FULL   = 2'd1,
        STATUS_BAD_VERSION = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROOT,
        ST_INSERT,
        ST_QUERY,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic        func;
        logic [9:0]  version_a;
        logic [9:0]  version_b;
        logic [31:0] key;
    } in_item_t;

    typedef struct packed {
        logic [31:0] max_xor;
        logic [1:0]  status;
    } out_item_t;

endpackage

// ===== rtl/persistent_trie_max_xor.sv =====
// Top level of the persistent trie max-xor block: sequencer, node pool RAM,
// version root RAM and result register. Depends on ptmx_pkg and ptmx_ram.
`timescale 1ns / 1ps

// Usage
//   s_valid/s_ready/s_data carry one item: an insert (func 0) that builds
//   version_a as version_b plus key, or a query (func 1) that returns the
//   greatest key XOR value over keys in version_a and not in version_b.
//   m_valid/m_ready/m_data return exactly one result item per input item.
// Sequencing
//   One item at a time. An insert does a root lookup, one node pool read
//   and write per trie level, KEY_BITS+1 levels, and the result load. A
//   query reads one level per key bit and ends early once both walks
//   meet on one node. A refused insert skips the trie walk. The next item
//   can be taken in the cycle after the result is loaded. The per-level
//   node pool read, whose data steers the next read address, sets the
//   pace of each walk.
// Reset
//   aresetn is synchronous, active low. After reset the block sweeps the
//   version root RAM, all VERSION_COUNT entries, with s_ready low; all versions
//   then read as the empty trie and the node pool is empty.
// Stalls
//   The result waits in an output register; the block takes the next item
//   and works on it while that result waits, and holds its own result
//   until the register is free.

module persistent_trie_max_xor #(
    parameter int NODE_COUNT    = 65536,
    parameter int VERSION_COUNT = 1024,
    parameter int KEY_BITS      = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ptmx_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ptmx_pkg::out_item_t m_data
);

    localparam int NW = $clog2(NODE_COUNT);
    localparam int VW = $clog2(VERSION_COUNT);
    localparam int CB = ptmx_pkg::COUNT_BITS;

    // Each node keeps its children and the key counts of both children,
    // so one read per version per level is enough to steer the walk.
    typedef struct packed {
        logic [NW-1:0] left;
        logic [NW-1:0] right;
        logic [CB-1:0] lcnt;
        logic [CB-1:0] rcnt;
    } node_t;

    // A version root entry holds the root node and the root's key count.
    typedef struct packed {
        logic [NW-1:0] root;
        logic [CB-1:0] cnt;
    } vroot_t;

    // Control state
    ptmx_pkg::state_t  state_reg, state_next;
    logic [VW-1:0]     clr_reg, clr_next;
    logic [NW-1:0]     next_free_reg, next_free_next;
    logic              m_valid_reg, m_valid_next;

    // Item payload and walk state
    logic              func_reg, func_next;
    logic              va_ok_reg, va_ok_next;
    logic              vb_ok_reg, vb_ok_next;
    logic              va_zero_reg, va_zero_next;
    logic [VW-1:0]     va_addr_reg, va_addr_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [KEY_BITS-1:0] mask_reg, mask_next;
    logic [KEY_BITS-1:0] res_reg, res_next;
    logic [NW-1:0]     p_reg, p_next;
    logic [NW-1:0]     q_reg, q_next;
    logic [NW-1:0]     cur_reg, cur_next;
    logic [1:0]        status_reg, status_next;
    ptmx_pkg::out_item_t out_reg, out_next;

    // RAM ports
    logic              node_we;
    logic [NW-1:0]     node_waddr;
    node_t             node_wdata;
    node_t             node_rd_a, node_rd_b;
    logic              ver_we;
    logic [VW-1:0]     ver_waddr;
    vroot_t            ver_wdata;
    logic [VW-1:0]     ver_raddr_a, ver_raddr_b;
    vroot_t            ver_rd_a, ver_rd_b;

    // Walk helpers
    node_t             p_word, q_word;
    vroot_t            root_a, root_b;
    logic [31:0]       va_wide, vb_wide;
    logic              kbit, want, take, dir;
    logic [CB-1:0]     cnt_p, cnt_q;
    logic              pool_full;

    ptmx_ram #(
        .WIDTH ($bits(node_t)),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .aclk    (aclk),
        .we      (node_we),
        .waddr   (node_waddr),
        .wdata   (node_wdata),
        .raddr_a (p_next),
        .rdata_a (node_rd_a),
        .raddr_b (q_next),
        .rdata_b (node_rd_b)
    );

    ptmx_ram #(
        .WIDTH ($bits(vroot_t)),
        .DEPTH (VERSION_COUNT)
    ) u_ver_ram (
        .aclk    (aclk),
        .we      (ver_we),
        .waddr   (ver_waddr),
        .wdata   (ver_wdata),
        .raddr_a (ver_raddr_a),
        .rdata_a (ver_rd_a),
        .raddr_b (ver_raddr_b),
        .rdata_b (ver_rd_b)
    );

    // Node 0 is the empty node and is never written: force it to zero.
    assign p_word = (p_reg == '0) ? '0 : node_rd_a;
    assign q_word = (q_reg == '0) ? '0 : node_rd_b;
    // Out-of-range versions read as the empty trie.
    assign root_a = va_ok_reg ? ver_rd_a : '0;
    assign root_b = vb_ok_reg ? ver_rd_b : '0;

    assign va_wide     = 32'(s_data.version_a);
    assign vb_wide     = 32'(s_data.version_b);
    assign ver_raddr_a = va_wide[VW-1:0];
    assign ver_raddr_b = vb_wide[VW-1:0];

    assign kbit  = |(key_reg & mask_reg);
    assign want  = ~kbit;
    assign cnt_p = want ? p_word.rcnt : p_word.lcnt;
    assign cnt_q = want ? q_word.rcnt : q_word.lcnt;
    assign take  = (cnt_p != cnt_q);
    assign dir   = take ? want : kbit;

    assign pool_full = (32'(next_free_reg) + 32'(KEY_BITS) + 32'd1)
                       > (32'(NODE_COUNT) - 32'd1);

    assign s_ready = (state_reg == ptmx_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        next_free_next = next_free_reg;
        m_valid_next   = m_valid_reg;
        func_next      = func_reg;
        va_ok_next     = va_ok_reg;
        vb_ok_next     = vb_ok_reg;
        va_zero_next   = va_zero_reg;
        va_addr_next   = va_addr_reg;
        key_next       = key_reg;
        mask_next      = mask_reg;
        res_next       = res_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        cur_next       = cur_reg;
        status_next    = status_reg;
        out_next       = out_reg;
        node_we        = 1'b0;
        node_waddr     = cur_reg;
        node_wdata     = '0;
        ver_we         = 1'b0;
        ver_waddr      = va_addr_reg;
        ver_wdata      = '0;

        // Drop the result once the receiver takes it.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ptmx_pkg::ST_CLEAR: begin
                ver_we    = 1'b1;
                ver_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == VW'(VERSION_COUNT - 1)) begin
                    state_next = ptmx_pkg::ST_IDLE;
                end
            end

            ptmx_pkg::ST_IDLE: begin
                // Root reads are issued from the input payload directly.
                if (s_valid) begin
                    func_next    = s_data.func;
                    va_ok_next   = va_wide < 32'(VERSION_COUNT);
                    vb_ok_next   = vb_wide < 32'(VERSION_COUNT);
                    va_zero_next = (s_data.version_a == '0);
                    va_addr_next = va_wide[VW-1:0];
                    key_next     = s_data.key[KEY_BITS-1:0];
                    mask_next    = KEY_BITS'(1) << (KEY_BITS - 1);
                    res_next     = '0;
                    status_next  = ptmx_pkg::STATUS_OK;
                    state_next   = ptmx_pkg::ST_ROOT;
                end
            end

            ptmx_pkg::ST_ROOT: begin
                if (func_reg == ptmx_pkg::FUNC_INSERT) begin
                    if (va_zero_reg || !va_ok_reg) begin
                        status_next = ptmx_pkg::STATUS_BAD_VERSION;
                        state_next  = ptmx_pkg::ST_DONE;
                    end else if (pool_full) begin
                        status_next = ptmx_pkg::STATUS_POOL_FULL;
                        state_next  = ptmx_pkg::ST_DONE;
                    end else begin
                        // New root takes the next free node; walk the base.
                        ver_we         = 1'b1;
                        ver_wdata.root = next_free_reg + 1'b1;
                        ver_wdata.cnt  = CB'(root_b.cnt + 1'b1);
                        cur_next       = next_free_reg + 1'b1;
                        p_next         = root_b.root;
                        state_next     = ptmx_pkg::ST_INSERT;
                    end
                end else begin
                    p_next = root_a.root;
                    q_next = root_b.root;
                    if (root_a.root == root_b.root) begin
                        state_next = ptmx_pkg::ST_DONE;
                    end else begin
                        state_next = ptmx_pkg::ST_QUERY;
                    end
                end
            end

            ptmx_pkg::ST_INSERT: begin
                node_we = 1'b1;
                if (mask_reg == '0) begin
                    // Leaf: no children, zero child counts.
                    next_free_next = cur_reg;
                    state_next     = ptmx_pkg::ST_DONE;
                end else begin
                    node_wdata = p_word;
                    if (kbit) begin
                        node_wdata.right = cur_reg + 1'b1;
                        node_wdata.rcnt  = CB'(p_word.rcnt + 1'b1);
                        p_next           = p_word.right;
                    end else begin
                        node_wdata.left = cur_reg + 1'b1;
                        node_wdata.lcnt = CB'(p_word.lcnt + 1'b1);
                        p_next          = p_word.left;
                    end
                    cur_next  = cur_reg + 1'b1;
                    mask_next = mask_reg >> 1;
                end
            end

            ptmx_pkg::ST_QUERY: begin
                // Prefer the branch opposite the key bit when counts differ.
                if (take) begin
                    res_next = res_reg | mask_reg;
                end
                p_next    = dir ? p_word.right : p_word.left;
                q_next    = dir ? q_word.right : q_word.left;
                mask_next = mask_reg >> 1;
                if (mask_reg[0] || (p_next == q_next)) begin
                    state_next = ptmx_pkg::ST_DONE;
                end
            end

            ptmx_pkg::ST_DONE: begin
                // Hold until the result register is free.
                if (!m_valid_reg || m_ready) begin
                    out_next.max_xor = 32'(res_reg);
                    out_next.status  = status_reg;
                    m_valid_next     = 1'b1;
                    state_next       = ptmx_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = ptmx_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ptmx_pkg::ST_CLEAR;
            clr_reg       <= '0;
            next_free_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            next_free_reg <= next_free_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg    <= func_next;
        va_ok_reg   <= va_ok_next;
        vb_ok_reg   <= vb_ok_next;
        va_zero_reg <= va_zero_next;
        va_addr_reg <= va_addr_next;
        key_reg     <= key_next;
        mask_reg    <= mask_next;
        res_reg     <= res_next;
        p_reg       <= p_next;
        q_reg       <= q_next;
        cur_reg     <= cur_next;
        status_reg  <= status_next;
        out_reg     <= out_next;
    end

endmodule

// ===== rtl/ptmx_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ptmx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for persistent_trie_max_xor: a trie predictor, a queue-fed
// driver and a monitor that checks each result against the oldest prediction.
// Depends on ptmx_pkg (item structs, func and status codes) and the block's RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int NODE_COUNT    = 65536;
    localparam int VERSION_COUNT = 1024;
    localparam int KEY_BITS      = 32;
    // Inserts that fit in the pool: each one takes KEY_BITS+1 nodes, node 0 stays empty.
    localparam int POOL_INSERTS  = (NODE_COUNT - 1) / (KEY_BITS + 1);
    localparam int RANDOM_ITEMS  = 1700;
    localparam int IDLE_PCT      = 27;
    // Window of accepted items in which neither side idles.
    localparam int CALM_FIRST    = 600;
    localparam int CALM_LAST     = 900;
    localparam int DRAIN_CYCLES  = 60;
    localparam int MAX_REPORTS   = 200;
    localparam int KEY_POOL_SIZE = 64;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    ptmx_pkg::in_item_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    ptmx_pkg::out_item_t m_data;

    persistent_trie_max_xor #(
        .NODE_COUNT   (NODE_COUNT),
        .VERSION_COUNT(VERSION_COUNT),
        .KEY_BITS     (KEY_BITS)
    ) uut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Hold reset low from the start, release it away from the rising edge.
    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
    end

    // ------------------------------------------------------------------
    // Trie predictor: its own node pool and version roots. Unwritten
    // entries read as zero; node 0 is the empty node, its own child.
    // ------------------------------------------------------------------
    bit [15:0] left_tab  [NODE_COUNT];
    bit [15:0] right_tab [NODE_COUNT];
    bit [10:0] count_tab [NODE_COUNT];
    bit [15:0] root_tab  [VERSION_COUNT];
    int        last_node = 0;

    function automatic int kid(int node, logic side);
        return side ? int'(right_tab[node]) : int'(left_tab[node]);
    endfunction

    function automatic ptmx_pkg::status_t trie_insert(logic [9:0] va, logic [9:0] vb,
                                                      logic [31:0] key);
        int   prev;
        int   node;
        int   lvl;
        logic bitv;
        // Version 0 is the permanent empty trie.
        if (va == '0)
            return ptmx_pkg::STATUS_BAD_VERSION;
        // Refuse when the new path would run past the last pool entry.
        if (last_node + KEY_BITS + 1 > NODE_COUNT - 1)
            return ptmx_pkg::STATUS_POOL_FULL;
        prev = int'(root_tab[vb]);
        node = last_node + 1;
        root_tab[va] = node[15:0];
        for (lvl = 0; lvl <= KEY_BITS; lvl++) begin
            // Count is 11 bits and wraps.
            count_tab[node] = count_tab[prev] + 11'd1;
            if (lvl == KEY_BITS) begin
                left_tab[node]  = '0;
                right_tab[node] = '0;
            end else begin
                bitv = key[KEY_BITS - 1 - lvl];
                if (bitv) begin
                    right_tab[node] = 16'(node + 1);
                    left_tab[node]  = left_tab[prev];
                end else begin
                    left_tab[node]  = 16'(node + 1);
                    right_tab[node] = right_tab[prev];
                end
                prev = kid(prev, bitv);
            end
            node++;
        end
        last_node = node - 1;
        return ptmx_pkg::STATUS_OK;
    endfunction

    function automatic logic [31:0] trie_query(logic [9:0] va, logic [9:0] vb,
                                               logic [31:0] key);
        int          p;
        int          q;
        int          lvl;
        logic        want;
        logic [31:0] acc;
        p   = int'(root_tab[va]);
        q   = int'(root_tab[vb]);
        acc = '0;
        for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
            // Once both walks share a node the difference below is empty.
            if (p == q)
                break;
            want = ~key[lvl];
            if (count_tab[kid(p, want)] != count_tab[kid(q, want)]) begin
                acc[lvl] = 1'b1;
                p = kid(p, want);
                q = kid(q, want);
            end else begin
                p = kid(p, ~want);
                q = kid(q, ~want);
            end
        end
        return acc;
    endfunction

    function automatic ptmx_pkg::out_item_t trie_predict(ptmx_pkg::in_item_t it);
        ptmx_pkg::out_item_t res;
        res.max_xor = '0;
        res.status  = ptmx_pkg::STATUS_OK;
        if (it.func == ptmx_pkg::FUNC_INSERT)
            res.status = trie_insert(it.version_a, it.version_b, it.key);
        else
            res.max_xor = trie_query(it.version_a, it.version_b, it.key);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation. Track which versions exist and what they were
    // built on, so queries mostly pair a version with one of its ancestors.
    // ------------------------------------------------------------------
    ptmx_pkg::in_item_t  pending_items[$];
    ptmx_pkg::out_item_t expected_results[$];
    bit [9:0]    parent_of[VERSION_COUNT];
    bit          made[VERSION_COUNT];
    int          made_list[$];
    logic [31:0] key_pool[$];
    int          live_inserts = 0;

    task automatic queue_item(logic f, logic [9:0] va, logic [9:0] vb, logic [31:0] key);
        ptmx_pkg::in_item_t it;
        it.func      = f;
        it.version_a = va;
        it.version_b = vb;
        it.key       = key;
        pending_items.push_back(it);
        // Track only inserts that the pool still has room for.
        if (f == ptmx_pkg::FUNC_INSERT && va != '0) begin
            live_inserts++;
            if (live_inserts <= POOL_INSERTS) begin
                parent_of[va] = vb;
                if (!made[va])
                    made_list.push_back(int'(va));
                made[va] = 1'b1;
                key_pool.push_back(key);
                if (key_pool.size() > KEY_POOL_SIZE)
                    void'(key_pool.pop_front());
            end
        end
    endtask

    function automatic logic [9:0] pick_version();
        if (made_list.size() == 0)
            return '0;
        return 10'(made_list[$urandom_range(0, made_list.size() - 1)]);
    endfunction

    // Keys near stored ones make the walks split deep in the trie.
    function automatic logic [31:0] pick_key();
        int          r;
        logic [31:0] k;
        r = $urandom_range(0, 99);
        if (r < 45 || key_pool.size() == 0)
            return $urandom;
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (r < 80)
            k = k ^ ($urandom & ((32'h1 << $urandom_range(0, 31)) - 32'h1));
        else if (r < 88)
            k = ~k;
        return k;
    endfunction

    task automatic gen_random_item(int insert_pct);
        int          r;
        int          steps;
        logic        f;
        logic [9:0]  va;
        logic [9:0]  vb;
        logic [31:0] key;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            // Noise: every field at random.
            f   = $urandom_range(0, 1) ? ptmx_pkg::FUNC_QUERY : ptmx_pkg::FUNC_INSERT;
            va  = 10'($urandom);
            vb  = 10'($urandom);
            key = $urandom;
        end else if ($urandom_range(0, 99) < insert_pct) begin
            f = ptmx_pkg::FUNC_INSERT;
            r = $urandom_range(0, 99);
            if (r < 70)
                va = 10'($urandom_range(1, VERSION_COUNT - 1));
            else if (r < 95)
                va = pick_version();
            else
                va = '0;
            r = $urandom_range(0, 99);
            if (r < 60)
                vb = pick_version();
            else if (r < 80)
                vb = va;
            else
                vb = '0;
            key = pick_key();
        end else begin
            f  = ptmx_pkg::FUNC_QUERY;
            va = ($urandom_range(0, 99) < 90) ? pick_version() : 10'($urandom);
            r  = $urandom_range(0, 99);
            if (r < 50) begin
                // Walk a few steps up the version history.
                vb    = va;
                steps = $urandom_range(1, 4);
                while (steps > 0 && vb != '0) begin
                    vb = parent_of[vb];
                    steps--;
                end
            end else if (r < 75) begin
                vb = '0;
            end else if (r < 90) begin
                vb = pick_version();
            end else begin
                vb = va;
            end
            key = pick_key();
        end
        queue_item(f, va, vb, key);
    endtask

    // ------------------------------------------------------------------
    // Driver: present items at the falling edge, hold until accepted.
    // ------------------------------------------------------------------
    logic s_taken  = 1'b0;
    int   items_in = 0;
    int   errors   = 0;

    always @(negedge aclk) begin
        bit calm;
        calm = (items_in >= CALM_FIRST && items_in < CALM_LAST);
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            // Hold a pending item; otherwise advance or idle.
            if (!(s_valid && !s_taken)) begin
                if (pending_items.size() != 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_items.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
        errors++;
        if (errors <= MAX_REPORTS)
            $error("%s: expected %h, actual %h", what, want, got);
    endtask

    // ------------------------------------------------------------------
    // Monitor: check results first, then predict for the accepted item, so
    // a result in the same cycle is matched against older items only.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        ptmx_pkg::out_item_t want;
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    flag_mismatch("unexpected result max_xor", '0, m_data.max_xor);
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.max_xor !== want.max_xor)
                        flag_mismatch("max_xor", want.max_xor, m_data.max_xor);
                    if (m_data.status !== want.status)
                        flag_mismatch("status", 32'(want.status), 32'(m_data.status));
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(trie_predict(s_data));
                items_in++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin
        // Empty trie, then the refused insert to version 0.
        queue_item(ptmx_pkg::FUNC_QUERY,  10'd0,    10'd0,    32'h0000_0000);
        queue_item(ptmx_pkg::FUNC_INSERT, 10'd0,    10'd0,    32'hFFFF_FFFF);
        // Build a short chain with extreme keys; top version index too.
        queue_item(ptmx_pkg::FUNC_INSERT, 10'd1,    10'd0,    32'h0000_0000);
        queue_item(ptmx_pkg::FUNC_INSERT, 10'd2,    10'd1,    32'hFFFF_FFFF);
        queue_item(ptmx_pkg::FUNC_INSERT, 10'd3,    10'd2,    32'h8000_0000);
        queue_item(ptmx_pkg::FUNC_INSERT, 10'd1023, 10'd3,    32'h0000_0001);
        queue_item(ptmx_pkg::FUNC_QUERY,  10'd1023, 10'd0,    32'h0000_0000);
        queue_item(ptmx_pkg::FUNC_QUERY,  10'd1023, 10'd3,    32'hFFFF_FFFF);
        queue_item(ptmx_pkg::FUNC_QUERY,  10'd3,    10'd1,    32'h0000_0000);
        // Same version on both sides: empty difference.
        queue_item(ptmx_pkg::FUNC_QUERY,  10'd1,    10'd1,    32'h1234_5678);
        // Unrelated and reversed versions.
        queue_item(ptmx_pkg::FUNC_QUERY,  10'd1,    10'd1023, 32'hFFFF_FFFF);
        queue_item(ptmx_pkg::FUNC_QUERY,  10'd0,    10'd1023, 32'h5555_5555);
        // Never-created version reads as empty.
        queue_item(ptmx_pkg::FUNC_QUERY,  10'd700,  10'd0,    32'hAAAA_AAAA);
        // Insert onto itself, then a duplicate key.
        queue_item(ptmx_pkg::FUNC_INSERT, 10'd4,    10'd4,    32'h5A5A_5A5A);
        queue_item(ptmx_pkg::FUNC_INSERT, 10'd5,    10'd1,    32'h0000_0000);
        queue_item(ptmx_pkg::FUNC_QUERY,  10'd5,    10'd1,    32'hFFFF_FFFF);
        queue_item(ptmx_pkg::FUNC_QUERY,  10'd5,    10'd0,    32'h1234_5678);
        // Overwrite the top version on top of itself.
        queue_item(ptmx_pkg::FUNC_INSERT, 10'd1023, 10'd1023, 32'h7FFF_FFFF);
        queue_item(ptmx_pkg::FUNC_QUERY,  10'd1023, 10'd1023, 32'h0000_0000);
        queue_item(ptmx_pkg::FUNC_QUERY,  10'd1023, 10'd3,    32'h8000_0000);
        queue_item(ptmx_pkg::FUNC_QUERY,  10'd1023, 10'd2,    32'h7FFF_FFFE);

        repeat (RANDOM_ITEMS)
            gen_random_item(65);

        // Drain: all items taken, all results back, then a quiet tail.
        while (pending_items.size() != 0 || s_valid)
            @(posedge aclk);
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0)
            flag_mismatch("missing results", '0, 32'(expected_results.size()));

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
